// ----- rtl/rfcc_pkg.sv -----
// Shared types and constants for the received-frame CRC checker.
// Holds the request payload structs, the verdict codes and the CRC-8 constants.
// No dependencies; rfcc_crc8 and rx_frame_crc_checker_core use this package.
`timescale 1ns / 1ps

package rfcc_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_MSB  = 8'h80;
    localparam logic [7:0] CRC_ZERO = 8'h00;

    // Header layout: part index, total parts, reserved, CRC-8.
    localparam int unsigned HDR_LEN = 4;
    localparam int unsigned POS_W   = 3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_SHORT   = 2'd2
    } t_frame_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
        logic [7:0] sender_address;
    } t_rx_item;

    typedef struct packed {
        logic          payload_valid;
        logic [7:0]    payload_byte;
        logic          frame_done;
        t_frame_status frame_status;
        logic [7:0]    fragment_index;
        logic [7:0]    fragment_total;
        logic [7:0]    sender_echo;
    } t_result_item;

endpackage

// ----- rtl/rfcc_stream_if.sv -----
// Valid/ready stream channel carrying one request payload per handshake.
// The payload type is a parameter; the block's structs come from rfcc_pkg.
`timescale 1ns / 1ps

interface rfcc_stream_if #(
    parameter type T_PAYLOAD = logic [7:0]
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/rfcc_crc8.sv -----
// Byte-wide CRC-8 update, MSB first, using the polynomial from rfcc_pkg.
// Purely combinational; instantiated by rx_frame_crc_checker_core.
`timescale 1ns / 1ps

module rfcc_crc8 (
    input  logic [7:0] i_crc,
    input  logic [7:0] i_data,
    output logic [7:0] o_crc
);

    always_comb begin
        logic [7:0] c;
        c = i_crc ^ i_data;
        for (int k = 0; k < 8; k++) begin
            if ((c & rfcc_pkg::CRC_MSB) != rfcc_pkg::CRC_ZERO) begin
                c = {c[6:0], 1'b0} ^ rfcc_pkg::CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

// ----- rtl/rx_frame_crc_checker_core.sv -----
// Top level of the received-frame CRC checker.
// Depends on rfcc_pkg, rfcc_stream_if and rfcc_crc8.
`timescale 1ns / 1ps

// The checker takes one frame byte per request, header first, and sustains
// one byte per clock cycle while the result channel is not stalled. A byte is
// captured into the input register when it is accepted, and its result then
// loads into the result register once that register is free, so each result
// request passes the input register, then the result register. Each frame
// opens with a four-byte header (part index, total parts, reserved, CRC-8)
// and the CRC-8 (polynomial 0x31, initial 0xFF, MSB first) runs over the
// whole frame with the header's CRC byte counted as zero. Payload bytes are
// forwarded as they arrive, each as its own result request, and the frame's
// last byte also carries the verdict: ok, CRC mismatch, or a short frame of
// four bytes or fewer. Header bytes that do not end the frame produce no
// result. Because payload is emitted before the verdict, the consumer must
// drop the frame's payload whenever the status is not ok. All frame state
// returns to its reset value after the last byte, so the next byte starts a
// new frame.

module rx_frame_crc_checker_core (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rfcc_stream_if.sink   i_rx,
    rfcc_stream_if.source o_res
);

    localparam logic [rfcc_pkg::POS_W-1:0] POS_PART  = rfcc_pkg::POS_W'(0);
    localparam logic [rfcc_pkg::POS_W-1:0] POS_TOTAL = rfcc_pkg::POS_W'(1);
    localparam logic [rfcc_pkg::POS_W-1:0] POS_CRC   = rfcc_pkg::POS_W'(3);
    localparam logic [rfcc_pkg::POS_W-1:0] POS_BODY  =
        rfcc_pkg::POS_W'(rfcc_pkg::HDR_LEN);

    // Input register stage.
    logic                r_in_valid;
    rfcc_pkg::t_rx_item  r_in;

    // Frame state.
    logic [7:0]                 r_crc;
    logic [rfcc_pkg::POS_W-1:0] r_pos;
    logic [7:0]                 r_hdr_part;
    logic [7:0]                 r_hdr_total;
    logic [7:0]                 r_rx_crc;

    // Result register stage.
    logic                   r_out_valid;
    rfcc_pkg::t_result_item r_out;

    logic                   is_payload;
    logic                   has_result;
    logic                   out_free;
    logic                   s1_adv;
    logic [7:0]             crc_data;
    logic [7:0]             crc_upd;
    logic [7:0]             n_crc;
    logic [rfcc_pkg::POS_W-1:0] n_pos;
    logic [7:0]             n_hdr_part;
    logic [7:0]             n_hdr_total;
    logic [7:0]             n_rx_crc;
    rfcc_pkg::t_result_item n_out;

    // Once the header is complete every byte is payload.
    assign is_payload = (r_pos == POS_BODY);
    assign has_result = is_payload || r_in.end_of_frame;

    // The output register is free when empty or being drained this cycle.
    assign out_free = !r_out_valid || o_res.ready;
    assign s1_adv   = r_in_valid && (!has_result || out_free);

    assign i_rx.ready  = !r_in_valid || s1_adv;
    assign o_res.valid = r_out_valid;
    assign o_res.payload = r_out;

    // The header's CRC byte enters the checksum as zero.
    assign crc_data = (r_pos == POS_CRC) ? rfcc_pkg::CRC_ZERO : r_in.rx_byte;

    rfcc_crc8 u_crc8 (
        .i_crc  (r_crc),
        .i_data (crc_data),
        .o_crc  (crc_upd)
    );

    always_comb begin
        n_hdr_part  = (r_pos == POS_PART)  ? r_in.rx_byte : r_hdr_part;
        n_hdr_total = (r_pos == POS_TOTAL) ? r_in.rx_byte : r_hdr_total;
        n_rx_crc    = (r_pos == POS_CRC)   ? r_in.rx_byte : r_rx_crc;
        n_pos       = is_payload ? r_pos : r_pos + rfcc_pkg::POS_W'(1);
        n_crc       = crc_upd;

        n_out                = '0;
        n_out.frame_status   = rfcc_pkg::ST_OK;
        if (is_payload) begin
            n_out.payload_valid = 1'b1;
            n_out.payload_byte  = r_in.rx_byte;
        end
        if (r_in.end_of_frame) begin
            n_out.frame_done     = 1'b1;
            n_out.fragment_index = n_hdr_part;
            n_out.fragment_total = n_hdr_total;
            n_out.sender_echo    = r_in.sender_address;
            if (!is_payload) begin
                n_out.frame_status = rfcc_pkg::ST_SHORT;
            end else if (crc_upd != r_rx_crc) begin
                n_out.frame_status = rfcc_pkg::ST_CRC_ERR;
            end else begin
                n_out.frame_status = rfcc_pkg::ST_OK;
            end
            // The last byte closes the frame: return to the reset state.
            n_hdr_part  = '0;
            n_hdr_total = '0;
            n_rx_crc    = '0;
            n_pos       = '0;
            n_crc       = rfcc_pkg::CRC_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
        if (i_rx.ready && i_rx.valid) begin
            r_in <= i_rx.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= rfcc_pkg::CRC_INIT;
            r_pos       <= '0;
            r_hdr_part  <= '0;
            r_hdr_total <= '0;
            r_rx_crc    <= '0;
        end else if (s1_adv) begin
            r_crc       <= n_crc;
            r_pos       <= n_pos;
            r_hdr_part  <= n_hdr_part;
            r_hdr_total <= n_hdr_total;
            r_rx_crc    <= n_rx_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_adv && has_result;
        end
        if (out_free && s1_adv && has_result) begin
            r_out <= n_out;
        end
    end

endmodule
